FILE: hdl/mroe_pkg.sv
// ----------------------------------------------------------------------------
// mroe_pkg: shared types and constants of the multi-range ohmmeter estimator
// Holds field widths, the ADC window, reset values of the reference
// resistors and the request and status types of the serial divider.
// ----------------------------------------------------------------------------
package mroe_pkg;

  // Field widths.
  localparam int ADC_W     = 12;
  localparam int REF_W     = 24;
  localparam int PARA_W    = 8;
  localparam int IDX_W     = 3;
  localparam int RES_W     = 32;
  localparam int CNT_W     = 4;
  localparam int SUM_W     = 36;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 24;

  // Resistor total and divider widths.
  localparam int RTOT_W     = REF_W + 1;
  localparam int PROD_W     = RTOT_W + ADC_W;
  localparam int DIVIDEND_W = PROD_W + 4;
  localparam int DIVISOR_W  = ADC_W;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

  // Number of reference resistor registers.
  localparam int NUM_REG_REFS = 6;

  // Register index of the parasitic resistance.
  localparam logic [CFG_IDX_W-1:0] CFG_PARASITIC = 3'd6;

  // ADC window and full scale.
  localparam logic [ADC_W-1:0] WIN_LOW  = 12'd300;
  localparam logic [ADC_W-1:0] WIN_HIGH = 12'd3700;
  localparam logic [ADC_W-1:0] ADC_FULL = 12'd4095;

  // Reset values of the reference resistors, entry 0 last.
  localparam logic [NUM_REG_REFS-1:0][REF_W-1:0] REF_RESET = {
    24'd470000, 24'd100000, 24'd47000, 24'd10000, 24'd1000, 24'd220
  };
  localparam logic [PARA_W-1:0] PARA_RESET = 8'd22;

  // Request to the serial divider.
  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  // Status of the serial divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: hdl/mroe_serial_div.sv
// ----------------------------------------------------------------------------
// mroe_serial_div: restoring divider, one quotient bit per cycle
// Shifts the dividend out at the top while quotient bits enter at the
// bottom. The quotient is ready in the cycle that done is high.
// ----------------------------------------------------------------------------
module mroe_serial_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mroe_pkg::div_req_t                req,
  output mroe_pkg::div_stat_t               stat,
  output logic [mroe_pkg::DIVIDEND_W-1:0]   quotient
);
  import mroe_pkg::*;

  localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIVIDEND_W - 1);

  logic [DIVIDEND_W-1:0] quo_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVISOR_W-1:0]  den_r;
  logic [DIV_CNT_W-1:0]  cnt_r;
  logic                  busy_r;
  logic                  done_r;

  logic [DIVISOR_W:0]    trial;
  logic                  fits;
  logic [DIVISOR_W-1:0]  rem_nxt;

  // One restoring step: bring down the next dividend bit and try the divisor.
  always_comb begin
    trial   = {rem_r, quo_r[DIVIDEND_W-1]};
    fits    = (trial >= {1'b0, den_r});
    rem_nxt = fits ? DIVISOR_W'(trial - {1'b0, den_r}) : trial[DIVISOR_W-1:0];
  end

  // Step counter and shift registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        quo_r  <= req.dividend;
        rem_r  <= '0;
        den_r  <= req.divisor;
      end else if (busy_r) begin
        quo_r <= {quo_r[DIVIDEND_W-2:0], fits};
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

FILE: hdl/mroe_cfg_regs.sv
// ----------------------------------------------------------------------------
// mroe_cfg_regs: configuration register file
// Holds the reference resistor values and the parasitic resistance, takes
// writes from the configuration channel and reads out the selected
// reference resistor.
// ----------------------------------------------------------------------------
module mroe_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en,
  input  logic [mroe_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [mroe_pkg::CFG_DAT_W-1:0]   wr_data,
  input  logic [mroe_pkg::IDX_W-1:0]       rd_index,
  output logic [mroe_pkg::REF_W-1:0]       ref_ohms,
  output logic [mroe_pkg::PARA_W-1:0]      parasitic_ohms
);
  import mroe_pkg::*;

  logic [NUM_REG_REFS-1:0][REF_W-1:0] ref_r;
  logic [PARA_W-1:0]                  para_r;

  // Register writes; an index past the parasitic register is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r  <= REF_RESET;
      para_r <= PARA_RESET;
    end else if (wr_en) begin
      if (32'(wr_index) < NUM_REG_REFS) begin
        ref_r[wr_index] <= wr_data[REF_W-1:0];
      end else if (wr_index == CFG_PARASITIC) begin
        para_r <= wr_data[PARA_W-1:0];
      end
    end
  end

  // Read of the selected reference resistor.
  always_comb begin
    if (32'(rd_index) < NUM_REG_REFS) begin
      ref_ohms = ref_r[rd_index];
    end else begin
      ref_ohms = '0;
    end
  end

  assign parasitic_ohms = para_r;

endmodule

FILE: hdl/multi_range_ohmmeter_estimator_top.sv
// ----------------------------------------------------------------------------
// multi_range_ohmmeter_estimator_top: voltage divider resistance estimator
// Turns pairs of averaged divider readings into a mean resistance in Q4.
// ----------------------------------------------------------------------------
// Usage:
// A request on the in_ channel carries one reference index and two readings.
// With a valid reference index, each reading strictly inside the ADC window
// yields one divider term that is added to a running sum. A request with
// in_last_range set closes the measurement: one result leaves on the out_
// channel with the mean, the number of used readings and a flag for a zero
// sum, and the sum clears. Requests are taken one at a time. Each used
// reading passes through the shared one-bit-per-cycle divider (41 steps),
// then trim and accumulate; a closing mean over a nonzero sum takes one
// more pass through the divider.
// The result waits in an output register; a new request is accepted while
// it waits, and a later result holds back until the receiver takes it.
// The cfg_ channel is always ready; writes belong in idle periods.
// Reset restores the default resistor values and clears sum and count.
// ----------------------------------------------------------------------------
module multi_range_ohmmeter_estimator_top #(
  parameter int NUM_REFS = 6
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [mroe_pkg::IDX_W-1:0]         in_ref_index,
  input  logic [mroe_pkg::ADC_W-1:0]         in_volts_toward_ground,
  input  logic [mroe_pkg::ADC_W-1:0]         in_volts_toward_supply,
  input  logic                               in_last_range,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [mroe_pkg::RES_W-1:0]         out_resistance_q4,
  output logic [mroe_pkg::CNT_W-1:0]         out_used_count,
  output logic                               out_no_reading,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mroe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mroe_pkg::CFG_DAT_W-1:0]     cfg_data
);
  import mroe_pkg::*;

  localparam logic [IDX_W:0] NUM_REFS_W = (IDX_W + 1)'(NUM_REFS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_TRIM,
    S_ACC,
    S_FINISH,
    S_MEAN,
    S_RESULT
  } state_t;

  state_t                state_r;
  logic [IDX_W-1:0]      idx_r;
  logic [ADC_W-1:0]      vg_r;
  logic [ADC_W-1:0]      vs_r;
  logic                  last_r;
  logic                  ref_ok_r;
  logic                  dir_r;
  logic [RES_W-1:0]      term_r;
  logic [SUM_W-1:0]      sum_r;
  logic [CNT_W-1:0]      count_r;
  logic [RES_W-1:0]      mean_r;
  logic                  zero_r;

  logic                  out_valid_r;
  logic [RES_W-1:0]      out_res_r;
  logic [CNT_W-1:0]      out_cnt_r;
  logic                  out_nor_r;

  logic [REF_W-1:0]      ref_sel;
  logic [PARA_W-1:0]     para;
  logic [RTOT_W-1:0]     rtot;
  logic [ADC_W-1:0]      v_cur;
  logic [ADC_W-1:0]      v_mul;
  logic [ADC_W-1:0]      v_den;
  logic                  use_cur;
  logic [PROD_W-1:0]     product;
  logic [DIVIDEND_W-1:0] quotient;
  logic [DIVIDEND_W-1:0] para_q4;
  logic [DIVIDEND_W-1:0] trimmed;
  logic [SUM_W:0]        sum_ext;
  logic                  sum_zero;
  logic                  in_acc;
  logic                  out_free;
  div_req_t              div_req;
  div_stat_t             div_stat;

  // Configuration registers.
  mroe_cfg_regs u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .wr_en          (cfg_valid & cfg_ready),
    .wr_index       (cfg_index),
    .wr_data        (cfg_data),
    .rd_index       (idx_r),
    .ref_ohms       (ref_sel),
    .parasitic_ohms (para)
  );

  // Shared serial divider for the divider terms and the mean.
  mroe_serial_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .stat     (div_stat),
    .quotient (quotient)
  );

  // Divider equation operands for the current drive direction.
  always_comb begin
    rtot    = {1'b0, ref_sel} + RTOT_W'(para);
    v_cur   = dir_r ? vs_r : vg_r;
    use_cur = ref_ok_r && (v_cur > WIN_LOW) && (v_cur < WIN_HIGH);
    if (dir_r) begin
      v_mul = ADC_FULL - v_cur;
      v_den = v_cur;
    end else begin
      v_mul = v_cur;
      v_den = ADC_FULL - v_cur;
    end
    product = PROD_W'(rtot) * PROD_W'(v_mul);
  end

  // Divider requests: a term in the check state, the mean when closing.
  always_comb begin
    sum_zero = (sum_r == '0) || (count_r == '0);
    div_req  = '0;
    if (state_r == S_CHECK && use_cur) begin
      div_req.start    = 1'b1;
      div_req.dividend = {product, 4'b0000};
      div_req.divisor  = v_den;
    end else if (state_r == S_FINISH && last_r && !sum_zero) begin
      div_req.start    = 1'b1;
      div_req.dividend = DIVIDEND_W'(sum_r);
      div_req.divisor  = DIVISOR_W'(count_r);
    end
  end

  // Parasitic removal and the saturating accumulate.
  always_comb begin
    para_q4 = DIVIDEND_W'({para, 4'b0000});
    trimmed = (quotient > para_q4) ? (quotient - para_q4) : '0;
    sum_ext = {1'b0, sum_r} + (SUM_W + 1)'(term_r);
  end

  assign in_acc   = in_valid & in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Sequencer, accumulator and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sum_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      dir_r       <= 1'b0;
    end else begin
      // Output valid rises when a result loads and falls when it is taken.
      if (state_r == S_RESULT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            idx_r    <= in_ref_index;
            vg_r     <= in_volts_toward_ground;
            vs_r     <= in_volts_toward_supply;
            last_r   <= in_last_range;
            ref_ok_r <= ({1'b0, in_ref_index} < NUM_REFS_W) &&
                        (32'(in_ref_index) < NUM_REG_REFS);
            dir_r    <= 1'b0;
            state_r  <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (use_cur) begin
            state_r <= S_DIV;
          end else if (!dir_r) begin
            dir_r <= 1'b1;
          end else begin
            state_r <= S_FINISH;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            state_r <= S_TRIM;
          end
        end
        S_TRIM: begin
          term_r  <= (|trimmed[DIVIDEND_W-1:RES_W]) ? '1 : trimmed[RES_W-1:0];
          state_r <= S_ACC;
        end
        S_ACC: begin
          sum_r <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
          if (count_r != '1) begin
            count_r <= count_r + 1'b1;
          end
          if (!dir_r) begin
            dir_r   <= 1'b1;
            state_r <= S_CHECK;
          end else begin
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!last_r) begin
            state_r <= S_IDLE;
          end else if (sum_zero) begin
            mean_r  <= '0;
            zero_r  <= 1'b1;
            state_r <= S_RESULT;
          end else begin
            state_r <= S_MEAN;
          end
        end
        S_MEAN: begin
          if (div_stat.done) begin
            mean_r  <= (|quotient[DIVIDEND_W-1:RES_W]) ? '1 : quotient[RES_W-1:0];
            zero_r  <= 1'b0;
            state_r <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (out_free) begin
            out_res_r   <= mean_r;
            out_cnt_r   <= count_r;
            out_nor_r   <= zero_r;
            sum_r       <= '0;
            count_r     <= '0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready          = (state_r == S_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_resistance_q4 = out_res_r;
  assign out_used_count    = out_cnt_r;
  assign out_no_reading    = out_nor_r;

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the multi-range ohmmeter estimator
// Drives reference index and divider reading pairs into the block and keeps
// its own Q4 divider arithmetic, running sum and count. It predicts the mean
// that each closing request should produce and checks every result field.
// The run passes through four phases with different idling, and the resistor
// and parasitic registers are rewritten between phases, including their extreme values.
// ----------------------------------------------------------------------------
module tb_top;
  import mroe_pkg::*;

  localparam int NUM_REFS = 6;
  localparam int CLK_HALF_NS = 2;
  localparam int RESET_CYCLES = 8;
  localparam int DRAIN_CYCLES = 300;
  localparam int PHASE_ITEMS = 375;
  localparam int MAX_REPORTS = 10;
  localparam longint TIMEOUT_NS = 8_000_000;
  localparam logic [63:0] Q4_MAX = 64'hFFFF_FFFF;
  localparam logic [63:0] SUM_MAX = 64'hF_FFFF_FFFF;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  // One expected result of a closed measurement.
  typedef struct {
    logic [RES_W-1:0] resistance;
    logic [CNT_W-1:0] used;
    logic             no_reading;
  } mean_result_t;

  // Predicts the mean of each measurement and checks what the block returns.
  class resistance_scoreboard;
    logic [REF_W-1:0]  ref_ohms [NUM_REG_REFS];
    logic [PARA_W-1:0] parasitic;
    logic [SUM_W-1:0]  resistance_sum;
    logic [CNT_W-1:0]  reading_count;
    mean_result_t      pending_means [$];
    int unsigned       errors;

    function new();
      for (int i = 0; i < NUM_REG_REFS; i++) ref_ohms[i] = REF_RESET[i];
      parasitic = PARA_RESET;
      resistance_sum = '0;
      reading_count = '0;
      errors = 0;
    endfunction

    function void apply_write(logic [CFG_IDX_W-1:0] index, logic [CFG_DAT_W-1:0] data);
      if (index < NUM_REG_REFS) begin
        ref_ohms[index] = data;
      end else if (index == CFG_PARASITIC) begin
        parasitic = data[PARA_W-1:0];
      end
    endfunction

    function bit in_window(logic [ADC_W-1:0] v);
      return (v > WIN_LOW) && (v < WIN_HIGH);
    endfunction

    // Divider equation in Q4 with the parasitic resistance removed.
    function logic [63:0] divider_term(logic [REF_W-1:0] rref, logic [ADC_W-1:0] v,
                                       bit toward_supply);
      logic [63:0] rtot;
      logic [63:0] num;
      logic [63:0] den;
      logic [63:0] q;
      logic [63:0] para_q4;
      rtot = 64'(rref) + 64'(parasitic);
      if (toward_supply) begin
        num = rtot * 64'(ADC_FULL - v);
        den = 64'(v);
      end else begin
        num = rtot * 64'(v);
        den = 64'(ADC_FULL - v);
      end
      q = (num << 4) / den;
      para_q4 = 64'(parasitic) << 4;
      q = (q > para_q4) ? q - para_q4 : 64'd0;
      return (q > Q4_MAX) ? Q4_MAX : q;
    endfunction

    function void accumulate(logic [63:0] term);
      logic [63:0] total;
      total = 64'(resistance_sum) + term;
      resistance_sum = (total > SUM_MAX) ? SUM_MAX[SUM_W-1:0] : total[SUM_W-1:0];
      if (reading_count != '1) reading_count++;
    endfunction

    function int pending();
      return pending_means.size();
    endfunction

    // Called for every accepted request.
    function void note_request(logic [IDX_W-1:0] idx, logic [ADC_W-1:0] vg,
                               logic [ADC_W-1:0] vs, logic last);
      logic [63:0]  mean;
      mean_result_t r;
      if (idx < NUM_REFS && idx < NUM_REG_REFS) begin
        if (in_window(vg)) accumulate(divider_term(ref_ohms[idx], vg, 1'b0));
        if (in_window(vs)) accumulate(divider_term(ref_ohms[idx], vs, 1'b1));
      end
      if (last) begin
        if (resistance_sum != '0 && reading_count != '0) begin
          mean = 64'(resistance_sum) / 64'(reading_count);
          r.resistance = (mean > Q4_MAX) ? Q4_MAX[RES_W-1:0] : mean[RES_W-1:0];
          r.no_reading = 1'b0;
        end else begin
          r.resistance = '0;
          r.no_reading = 1'b1;
        end
        r.used = reading_count;
        pending_means.push_back(r);
        resistance_sum = '0;
        reading_count = '0;
      end
    endfunction

    // Called for every accepted result.
    function void check_result(logic [RES_W-1:0] res, logic [CNT_W-1:0] used,
                               logic no_rd);
      mean_result_t want;
      if (pending_means.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("ERROR: result with none pending: res=%0d used=%0d none=%0b",
                   res, used, no_rd);
        return;
      end
      want = pending_means.pop_front();
      if (res !== want.resistance || used !== want.used || no_rd !== want.no_reading) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("ERROR: res exp=%0d got=%0d, used exp=%0d got=%0d, none exp=%0b got=%0b",
                   want.resistance, res, want.used, used, want.no_reading, no_rd);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [IDX_W-1:0] in_ref_index = '0;
  logic [ADC_W-1:0] in_volts_toward_ground = '0;
  logic [ADC_W-1:0] in_volts_toward_supply = '0;
  logic in_last_range = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [RES_W-1:0] out_resistance_q4;
  logic [CNT_W-1:0] out_used_count;
  logic out_no_reading;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  int send_idle_pct = 0;
  int stall_pct = 0;
  resistance_scoreboard sb;

  multi_range_ohmmeter_estimator_top #(.NUM_REFS(NUM_REFS)) DUT (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_ref_index           (in_ref_index),
    .in_volts_toward_ground (in_volts_toward_ground),
    .in_volts_toward_supply (in_volts_toward_supply),
    .in_last_range          (in_last_range),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_resistance_q4      (out_resistance_q4),
    .out_used_count         (out_used_count),
    .out_no_reading         (out_no_reading),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data)
  );

  // Clock.
  initial begin
    forever #(CLK_HALF_NS) clk = ~clk;
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Observe every handshake at the clock edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        sb.check_result(out_resistance_q4, out_used_count, out_no_reading);
      if (in_valid && in_ready)
        sb.note_request(in_ref_index, in_volts_toward_ground, in_volts_toward_supply,
                        in_last_range);
      if (cfg_valid && cfg_ready) sb.apply_write(cfg_index, cfg_data);
    end
  end

  // Present one request, with a random idle gap first, and wait until taken.
  task automatic send_request(logic [IDX_W-1:0] idx, logic [ADC_W-1:0] vg,
                              logic [ADC_W-1:0] vs, logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_ref_index <= idx;
    in_volts_toward_ground <= vg;
    in_volts_toward_supply <= vs;
    in_last_range <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Register write; valid stays high so that back-to-back writes need no dip.
  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Wait for every pending result, then let the block settle. The first
  // edge lets the monitor note the request taken at the previous edge.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [IDX_W-1:0] random_index();
    if ($urandom_range(15) == 0) return IDX_W'($urandom_range(7, NUM_REFS));
    return IDX_W'($urandom_range(NUM_REFS - 1));
  endfunction

  // Mostly usable readings, some around the window edges, some anywhere.
  function automatic logic [ADC_W-1:0] random_reading();
    int pick;
    pick = $urandom_range(9);
    if (pick < 7) return ADC_W'($urandom_range(3699, 301));
    if (pick == 7) begin
      if ($urandom_range(1) == 1) return ADC_W'($urandom_range(305, 295));
      return ADC_W'($urandom_range(3705, 3695));
    end
    return ADC_W'($urandom);
  endfunction

  // Measurements of a few ranges each, now and then a long one.
  task automatic run_random(int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(19) == 0) ? $urandom_range(13, 8) : $urandom_range(4, 1);
      for (int k = 0; k < len; k++)
        send_request(random_index(), random_reading(), random_reading(), k == len - 1);
      sent += len;
    end
  endtask

  // Main sequence.
  initial begin
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Phase without idling, default registers; directed cases first.
    send_request(3'd0, 12'd301, 12'd3699, 1'b1);  // both readings just inside
    send_request(3'd1, 12'd300, 12'd3700, 1'b1);  // both on the window edge
    send_request(3'd2, 12'd0, 12'd4095, 1'b0);    // rail readings are dropped
    send_request(3'd5, 12'd4095, 12'd0, 1'b0);
    send_request(3'd3, 12'd2048, 12'd2048, 1'b1);
    send_request(3'd6, 12'd2000, 12'd2000, 1'b0); // no register behind it
    send_request(3'd7, 12'd1000, 12'd1000, 1'b1); // still closes, sum is zero
    send_request(3'd0, 12'd301, 12'd0, 1'b1);     // term lost to parasitic
    run_random(PHASE_ITEMS);
    drain();

    // Extreme resistor values, largest parasitic, sender idling.
    write_reg(3'd0, 24'd1);
    write_reg(3'd1, 24'hFF_FFFF);
    write_reg(3'd2, 24'd0);
    for (int i = 3; i < NUM_REG_REFS; i++) write_reg(i[CFG_IDX_W-1:0], 24'($urandom));
    write_reg(CFG_PARASITIC, 24'd255);
    write_reg(CFG_UNUSED, 24'($urandom));
    cfg_valid <= 1'b0;
    send_idle_pct = 64;
    stall_pct = 0;
    // Saturate both the sum and the count with the largest reference.
    for (int k = 0; k < 12; k++) send_request(3'd1, 12'd3699, 12'd301, k == 11);
    send_request(3'd2, 12'd2000, 12'd2000, 1'b1); // zero reference resistor
    run_random(PHASE_ITEMS);
    drain();

    // Random resistor magnitudes, no parasitic, receiver stalling.
    for (int i = 0; i < NUM_REG_REFS; i++)
      write_reg(i[CFG_IDX_W-1:0], 24'($urandom >> $urandom_range(31, 8)));
    write_reg(CFG_PARASITIC, 24'd0);
    cfg_valid <= 1'b0;
    send_idle_pct = 0;
    stall_pct = 64;
    run_random(PHASE_ITEMS);
    drain();

    // Default resistors, random parasitic, both sides idling.
    for (int i = 0; i < NUM_REG_REFS; i++) write_reg(i[CFG_IDX_W-1:0], REF_RESET[i]);
    write_reg(CFG_PARASITIC, 24'($urandom_range(255)));
    cfg_valid <= 1'b0;
    send_idle_pct = 27;
    stall_pct = 27;
    run_random(PHASE_ITEMS);
    drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

endmodule

FILE: sim.f
hdl/mroe_pkg.sv
hdl/mroe_serial_div.sv
hdl/mroe_cfg_regs.sv
hdl/multi_range_ohmmeter_estimator_top.sv
verif/tb_top.sv
